[sv/rbm_pkg.sv]
// rbm_pkg: shared types, register indexes, level codes and defaults for the
// raid block mapper. No dependencies.

package rbm_pkg;

  // default sizing
  localparam int MAX_DISKS_DEF = 16;
  localparam int LBA_BITS_DEF  = 32;
  localparam int MAX_RUN_DEF   = 64;

  // field widths fixed by the interface
  localparam int LBA_W    = 32;
  localparam int COUNT_W  = 7;
  localparam int STRIP_W  = 16;
  localparam int DISKS_W  = 5;
  localparam int DISK_W   = 4;
  localparam int CFG_IDX_W = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RAID_LEVEL   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STRIP_BLOCKS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DISK_COUNT   = 2'd2;

  // raid level codes
  localparam logic [1:0] LVL_STRIPE = 2'd0;
  localparam logic [1:0] LVL_MIRROR = 2'd1;
  localparam logic [1:0] LVL_PARITY = 2'd2;
  localparam logic [1:0] LVL_ROTATE = 2'd3;

  // sequencer states
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_DIVS = 6'b000010,
    S_DIVA = 6'b000100,
    S_DIVB = 6'b001000,
    S_MUL  = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

endpackage

[sv/raid_block_mapper_top.sv]
// raid_block_mapper_top: maps a run of logical blocks to data disk, disk block
// and partner disk for RAID 0, 10, 4 and 5 with one shared restoring divider.
// Depends on rbm_pkg.
// Per block the divider first computes lba / strip, then the stripe division,
// then for levels 1 and 3 a second small division; the S_MUL state forms the
// strip product and S_OUT hands the result on. The blocks of a request are
// mapped one after another; the divider and output back-pressure set the rate.
// in_tready is high only when idle; the last result may wait while the next
// request is taken. Synchronous active-low reset clears control and config.

module raid_block_mapper_top #(
  parameter int MAX_DISKS = rbm_pkg::MAX_DISKS_DEF,
  parameter int LBA_BITS  = rbm_pkg::LBA_BITS_DEF,
  parameter int MAX_RUN   = rbm_pkg::MAX_RUN_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input items
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // start_lba[31:0], block_count[38:32], zero pad
  // result items
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // data_disk[3:0], disk_block[35:4],
                                  // partner_disk[39:36], partner_used[40],
                                  // config_error[41], zero pad
  output logic        out_tlast,
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [rbm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int AW  = LBA_BITS;
  localparam int CW  = $clog2(AW);
  localparam int SW  = rbm_pkg::STRIP_W;
  localparam int DW  = rbm_pkg::DISKS_W;
  localparam int NW  = rbm_pkg::COUNT_W;

  // configuration registers
  logic [1:0]    raid_level_r;
  logic [SW-1:0] strip_blocks_r;
  logic [DW-1:0] disk_count_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raid_level_r   <= rbm_pkg::LVL_STRIPE;
      strip_blocks_r <= SW'(1);
      disk_count_r   <= DW'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rbm_pkg::REG_RAID_LEVEL:   raid_level_r   <= cfg_data[1:0];
        rbm_pkg::REG_STRIP_BLOCKS: strip_blocks_r <= cfg_data[SW-1:0];
        rbm_pkg::REG_DISK_COUNT:   disk_count_r   <= cfg_data[DW-1:0];
        default: ;
      endcase
    end
  end

  // effective geometry
  logic [SW-1:0] strip_eff;
  logic [DW-1:0] d_eff;
  logic [DW-1:0] half_eff;
  logic [DW-1:0] per_eff;
  logic          cfg_err;

  always_comb begin
    strip_eff = (strip_blocks_r == '0) ? SW'(1) : strip_blocks_r;
    cfg_err   = 1'b0;
    if (disk_count_r == '0) begin
      d_eff   = DW'(1);
      cfg_err = 1'b1;
    end else if (32'(disk_count_r) > 32'(MAX_DISKS)) begin
      d_eff   = DW'(MAX_DISKS);
      cfg_err = 1'b1;
    end else begin
      d_eff   = disk_count_r;
    end
    half_eff = (d_eff < DW'(2)) ? DW'(1) : (d_eff >> 1);
    per_eff  = (d_eff < DW'(2)) ? DW'(1) : (d_eff - DW'(1));
    case (raid_level_r) inside
      rbm_pkg::LVL_MIRROR: if (d_eff[0]) cfg_err = 1'b1;
      rbm_pkg::LVL_PARITY, rbm_pkg::LVL_ROTATE: if (d_eff < DW'(3)) cfg_err = 1'b1;
      default: ;
    endcase
  end

  // sequencer and datapath registers
  rbm_pkg::state_t state_r, state_nxt;
  logic [AW-1:0] addr_r, addr_nxt;
  logic [NW-1:0] left_r, left_nxt;
  logic [AW-1:0] s_r, s_nxt;
  logic [SW-1:0] o_r, o_nxt;
  logic [AW-1:0] stripe_r, stripe_nxt;
  logic [DW-1:0] ra_r, ra_nxt;
  logic [DW-1:0] rb_r, rb_nxt;
  logic [31:0]   prod_r, prod_nxt;

  // shared divider registers
  logic [AW-1:0] quo_r, quo_nxt;
  logic [SW-1:0] rem_r, rem_nxt;
  logic [SW-1:0] dvs_r, dvs_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  // output registers
  logic          out_valid_r, out_valid_nxt;
  logic          out_last_r, out_last_nxt;
  logic [47:0]   out_data_r, out_data_nxt;

  // one restoring division step
  logic [SW:0]   trial;
  logic [SW:0]   diff;
  logic          ge;
  logic [SW-1:0] rem_step;
  logic [AW-1:0] quo_step;

  always_comb begin
    trial    = {rem_r, quo_r[AW-1]};
    ge       = trial >= {1'b0, dvs_r};
    diff     = trial - {1'b0, dvs_r};
    rem_step = ge ? diff[SW-1:0] : trial[SW-1:0];
    quo_step = {quo_r[AW-2:0], ge};
  end

  // input field decode
  logic [AW+31:0] lba_ext;
  logic [AW-1:0]  lba_in;
  logic [NW-1:0]  count_in;
  logic [NW-1:0]  count_sat;
  logic [AW+31:0] stripe_ext;

  always_comb begin
    lba_ext    = {{AW{1'b0}}, in_tdata[31:0]};
    lba_in     = lba_ext[AW-1:0];
    count_in   = in_tdata[38:32];
    count_sat  = (count_in > NW'(MAX_RUN)) ? NW'(MAX_RUN) : count_in;
    stripe_ext = {32'b0, stripe_r};
  end

  // disk selection from the stored remainders
  logic [DW:0]   d6;
  logic [DW:0]   two6;
  logic [DW:0]   par6;
  logic [DW:0]   disk6;
  logic [DW:0]   part6;
  logic          used;

  always_comb begin
    d6    = {1'b0, d_eff};
    two6  = {rb_r, 1'b0};
    par6  = '0;
    disk6 = '0;
    part6 = '0;
    used  = 1'b1;
    case (raid_level_r)
      rbm_pkg::LVL_STRIPE: begin
        disk6 = {1'b0, ra_r};
        used  = 1'b0;
      end
      rbm_pkg::LVL_MIRROR: begin
        disk6 = (two6 >= d6) ? (two6 - d6) : two6;
        part6 = ((disk6 + (DW+1)'(1)) == d6) ? '0 : (disk6 + (DW+1)'(1));
      end
      default: begin
        par6  = (raid_level_r == rbm_pkg::LVL_PARITY) ? (d6 - (DW+1)'(1))
                                                      : {1'b0, rb_r};
        disk6 = ({1'b0, ra_r} >= par6) ? ({1'b0, ra_r} + (DW+1)'(1)) : {1'b0, ra_r};
        part6 = par6;
      end
    endcase
  end

  // sequencer
  logic [31:0] block_val;

  always_comb begin
    state_nxt     = state_r;
    addr_nxt      = addr_r;
    left_nxt      = left_r;
    s_nxt         = s_r;
    o_nxt         = o_r;
    stripe_nxt    = stripe_r;
    ra_nxt        = ra_r;
    rb_nxt        = rb_r;
    prod_nxt      = prod_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    dvs_nxt       = dvs_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_last_nxt  = out_last_r;
    out_data_nxt  = out_data_r;
    block_val     = prod_r + {{(32-SW){1'b0}}, o_r};

    unique case (state_r)
      rbm_pkg::S_IDLE: begin
        if (in_tvalid) begin
          addr_nxt = lba_in;
          left_nxt = count_sat;
          if (count_sat != '0) begin
            quo_nxt   = lba_in;
            rem_nxt   = '0;
            dvs_nxt   = strip_eff;
            cnt_nxt   = CW'(AW - 1);
            state_nxt = rbm_pkg::S_DIVS;
          end
        end
      end

      // lba / strip
      rbm_pkg::S_DIVS: begin
        quo_nxt = quo_step;
        rem_nxt = rem_step;
        cnt_nxt = cnt_r - CW'(1);
        if (cnt_r == '0) begin
          s_nxt   = quo_step;
          o_nxt   = rem_step;
          quo_nxt = quo_step;
          rem_nxt = '0;
          cnt_nxt = CW'(AW - 1);
          case (raid_level_r)
            rbm_pkg::LVL_STRIPE: dvs_nxt = {{(SW-DW){1'b0}}, d_eff};
            rbm_pkg::LVL_MIRROR: dvs_nxt = {{(SW-DW){1'b0}}, half_eff};
            default:             dvs_nxt = {{(SW-DW){1'b0}}, per_eff};
          endcase
          state_nxt = rbm_pkg::S_DIVA;
        end
      end

      // stripe division: s by d, half or per
      rbm_pkg::S_DIVA: begin
        quo_nxt = quo_step;
        rem_nxt = rem_step;
        cnt_nxt = cnt_r - CW'(1);
        if (cnt_r == '0) begin
          stripe_nxt = quo_step;
          ra_nxt     = rem_step[DW-1:0];
          rem_nxt    = '0;
          cnt_nxt    = CW'(AW - 1);
          dvs_nxt    = {{(SW-DW){1'b0}}, d_eff};
          case (raid_level_r)
            rbm_pkg::LVL_MIRROR: begin
              quo_nxt   = s_r;
              state_nxt = rbm_pkg::S_DIVB;
            end
            rbm_pkg::LVL_ROTATE: begin
              quo_nxt   = quo_step;
              state_nxt = rbm_pkg::S_DIVB;
            end
            default: state_nxt = rbm_pkg::S_MUL;
          endcase
        end
      end

      // s mod d for mirrors, stripe mod d for rotating parity
      rbm_pkg::S_DIVB: begin
        quo_nxt = quo_step;
        rem_nxt = rem_step;
        cnt_nxt = cnt_r - CW'(1);
        if (cnt_r == '0) begin
          rb_nxt    = rem_step[DW-1:0];
          state_nxt = rbm_pkg::S_MUL;
        end
      end

      // low word of stripe * strip
      rbm_pkg::S_MUL: begin
        prod_nxt  = 32'(stripe_ext[31:0] * {{(32-SW){1'b0}}, strip_eff});
        state_nxt = rbm_pkg::S_OUT;
      end

      // hand the item to the output register, then next block
      rbm_pkg::S_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_last_nxt  = (left_r == NW'(1));
          out_data_nxt  = {6'b0, cfg_err, used, part6[3:0], block_val, disk6[3:0]};
          left_nxt      = left_r - NW'(1);
          addr_nxt      = addr_r + AW'(1);
          if (left_r == NW'(1)) begin
            state_nxt = rbm_pkg::S_IDLE;
          end else begin
            quo_nxt   = addr_r + AW'(1);
            rem_nxt   = '0;
            dvs_nxt   = strip_eff;
            cnt_nxt   = CW'(AW - 1);
            state_nxt = rbm_pkg::S_DIVS;
          end
        end
      end

      default: state_nxt = rbm_pkg::S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rbm_pkg::S_IDLE;
      addr_r      <= '0;
      left_r      <= '0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      addr_r      <= addr_nxt;
      left_r      <= left_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    s_r        <= s_nxt;
    o_r        <= o_nxt;
    stripe_r   <= stripe_nxt;
    ra_r       <= ra_nxt;
    rb_r       <= rb_nxt;
    prod_r     <= prod_nxt;
    quo_r      <= quo_nxt;
    rem_r      <= rem_nxt;
    dvs_r      <= dvs_nxt;
    out_last_r <= out_last_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_tready  = (state_r == rbm_pkg::S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

[sim/raid_block_mapper_checker.sv]
// raid_block_mapper_checker: watches the request, result and register channels
// of raid_block_mapper_top, predicts every block mapping and compares it.
// Depends on rbm_pkg.

module raid_block_mapper_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  input  logic                          in_tready,
  input  logic [39:0]                   in_tdata,   // start_lba[31:0], block_count[38:32]
  input  logic                          out_tvalid,
  input  logic                          out_tready,
  input  logic [47:0]                   out_tdata,  // data_disk, disk_block, partner_disk,
                                                    // partner_used, config_error
  input  logic                          out_tlast,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [rbm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                   cfg_data,
  output int                            fail_count,
  output int                            pending,
  output int                            results_checked
);

  typedef struct {
    logic [3:0]  data_disk;
    logic [31:0] disk_block;
    logic [3:0]  partner_disk;
    logic        partner_used;
    logic        config_error;
    logic        last;
  } block_map_t;

  // array setting as last written
  logic [1:0]  level_cfg;
  logic [15:0] strip_cfg;
  logic [4:0]  disks_cfg;

  block_map_t expected_maps[$];

  // disk placement of one logical block under the current setting
  function automatic block_map_t locate_block(input logic [31:0] lba);
    longint unsigned strip, d, s, o, half, per, stripe, parity, disk, blk, partner;
    logic err, used;
    block_map_t m;
    strip = (strip_cfg == 16'd0) ? 1 : strip_cfg;
    d = disks_cfg;
    err = 1'b0;
    used = 1'b0;
    disk = 0;
    blk = 0;
    partner = 0;
    // out-of-range disk counts are clamped but flagged
    if (d < 1) begin
      d = 1;
      err = 1'b1;
    end
    if (d > rbm_pkg::MAX_DISKS_DEF) begin
      d = rbm_pkg::MAX_DISKS_DEF;
      err = 1'b1;
    end
    s = lba / strip;
    o = lba % strip;
    case (level_cfg) inside
      rbm_pkg::LVL_STRIPE: begin
        disk = s % d;
        blk = o + (s / d) * strip;
      end
      rbm_pkg::LVL_MIRROR: begin
        half = d / 2;
        if (d[0]) err = 1'b1;
        if (half < 1) half = 1;
        disk = (s * 2) % d;
        blk = o + (s / half) * strip;
        partner = (disk + 1) % d;
        used = 1'b1;
      end
      rbm_pkg::LVL_PARITY, rbm_pkg::LVL_ROTATE: begin
        per = d - 1;
        if (d < 3) err = 1'b1;
        if (per < 1) per = 1;
        stripe = s / per;
        parity = (level_cfg == rbm_pkg::LVL_PARITY) ? d - 1 : stripe % d;
        disk = s % per;
        // data disks skip over the parity disk
        if (disk >= parity) disk++;
        blk = o + stripe * strip;
        partner = parity;
        used = 1'b1;
      end
    endcase
    m.data_disk    = disk[3:0];
    m.disk_block   = blk[31:0];
    m.partner_disk = partner[3:0];
    m.partner_used = used;
    m.config_error = err;
    m.last         = 1'b0;
    return m;
  endfunction

  // one expected mapping per block of the request, address wraps at 32 bits
  task automatic expand_request(input logic [31:0] start_lba, input logic [6:0] count);
    logic [31:0] next_lba;
    int unsigned blocks_to_go;
    block_map_t m;
    next_lba = start_lba;
    blocks_to_go = count;
    if (blocks_to_go > rbm_pkg::MAX_RUN_DEF) blocks_to_go = rbm_pkg::MAX_RUN_DEF;
    while (blocks_to_go > 0) begin
      m = locate_block(next_lba);
      blocks_to_go--;
      m.last = (blocks_to_go == 0);
      expected_maps.push_back(m);
      next_lba = next_lba + 32'd1;
    end
  endtask

  // compare a result item against the oldest expected mapping
  task automatic check_result(input logic [47:0] data, input logic tlast);
    block_map_t want;
    if (expected_maps.size() == 0) begin
      $error("unexpected result item: disk %0d block %0h last %0b",
             data[3:0], data[35:4], tlast);
      fail_count++;
    end else begin
      want = expected_maps.pop_front();
      results_checked++;
      if (data[3:0] != want.data_disk) begin
        $error("data_disk: expected %0d, actual %0d", want.data_disk, data[3:0]);
        fail_count++;
      end
      if (data[35:4] != want.disk_block) begin
        $error("disk_block: expected %0h, actual %0h", want.disk_block, data[35:4]);
        fail_count++;
      end
      if (data[39:36] != want.partner_disk) begin
        $error("partner_disk: expected %0d, actual %0d", want.partner_disk, data[39:36]);
        fail_count++;
      end
      if (data[40] != want.partner_used) begin
        $error("partner_used: expected %0b, actual %0b", want.partner_used, data[40]);
        fail_count++;
      end
      if (data[41] != want.config_error) begin
        $error("config_error: expected %0b, actual %0b", want.config_error, data[41]);
        fail_count++;
      end
      if (tlast != want.last) begin
        $error("last: expected %0b, actual %0b", want.last, tlast);
        fail_count++;
      end
    end
  endtask

  // sample all three channels at the rising edge
  always @(posedge clk) begin
    if (!rst_n) begin
      level_cfg = rbm_pkg::LVL_STRIPE;
      strip_cfg = 16'd1;
      disks_cfg = 5'd1;
      expected_maps.delete();
    end else begin
      if (out_tvalid && out_tready) check_result(out_tdata, out_tlast);
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          rbm_pkg::REG_RAID_LEVEL:   level_cfg = cfg_data[1:0];
          rbm_pkg::REG_STRIP_BLOCKS: strip_cfg = cfg_data;
          rbm_pkg::REG_DISK_COUNT:   disks_cfg = cfg_data[4:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) expand_request(in_tdata[31:0], in_tdata[38:32]);
    end
    pending = expected_maps.size();
  end

endmodule

[sim/tb_raid_block_mapper_top.sv]
// tb_raid_block_mapper_top: drives block requests and array settings into
// raid_block_mapper_top and gives the verdict from raid_block_mapper_checker.
// Depends on rbm_pkg, raid_block_mapper_top and raid_block_mapper_checker.

module tb_raid_block_mapper_top;

  localparam int SETTLE_CYCLES        = 3 * rbm_pkg::LBA_BITS_DEF + 40;
  localparam int CYCLE_LIMIT          = 8_000_000;
  localparam int RANDOM_REQUESTS      = 120;
  localparam int REQUESTS_PER_SETTING = 14;

  logic                          clk;
  logic                          rst_n      = 1'b0;
  logic                          in_tvalid  = 1'b0;
  logic                          in_tready;
  logic [39:0]                   in_tdata   = '0;
  logic                          out_tvalid;
  logic                          out_tready = 1'b0;
  logic [47:0]                   out_tdata;
  logic                          out_tlast;
  logic                          cfg_valid  = 1'b0;
  logic                          cfg_ready;
  logic [rbm_pkg::CFG_IDX_W-1:0] cfg_index  = '0;
  logic [15:0]                   cfg_data   = '0;

  int fail_count;
  int pending;
  int results_checked;
  int send_idle      = 30;
  int recv_idle      = 50;
  int requests_sent  = 0;
  int settings_used  = 0;

  raid_block_mapper_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  raid_block_mapper_checker chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tlast       (out_tlast),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .fail_count      (fail_count),
    .pending         (pending),
    .results_checked (results_checked)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // result side back-pressure
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle);
  end

  // hard stop if the block hangs
  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("tb_raid_block_mapper_top NOT OK");
    $finish;
  end

  // called at a falling edge; valid stays high afterwards for back-to-back items
  task automatic push_request(input logic [31:0] lba, input logic [6:0] count);
    if ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < send_idle);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, count, lba};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    requests_sent++;
  endtask

  // wait until every predicted block has come out and the block is idle
  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [rbm_pkg::CFG_IDX_W-1:0] idx,
                           input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // unused upper data bits carry noise, the block keeps only the low ones
  task automatic apply_setting(input logic [1:0] lvl, input logic [15:0] strip,
                               input logic [4:0] disks);
    logic [15:0] noise;
    drain();
    noise = 16'($urandom);
    write_reg(rbm_pkg::REG_RAID_LEVEL, {noise[15:2], lvl});
    write_reg(rbm_pkg::REG_STRIP_BLOCKS, strip);
    noise = 16'($urandom);
    write_reg(rbm_pkg::REG_DISK_COUNT, {noise[15:5], disks});
    settings_used++;
  endtask

  // mostly legal arrays, sometimes a count the level rejects
  task automatic random_setting();
    logic [1:0]  lvl;
    logic [15:0] strip;
    logic [4:0]  disks;
    lvl = 2'($urandom_range(3));
    case ($urandom_range(9)) inside
      0:       strip = 16'd0;
      1:       strip = 16'hFFFF;
      2, 3:    strip = 16'($urandom);
      default: strip = 16'($urandom_range(8, 1));
    endcase
    if ($urandom_range(6) == 0) disks = 5'($urandom);
    else if (lvl == rbm_pkg::LVL_MIRROR) disks = 5'(2 * $urandom_range(8, 1));
    else if (lvl == rbm_pkg::LVL_STRIPE) disks = 5'($urandom_range(16, 1));
    else disks = 5'($urandom_range(16, 3));
    apply_setting(lvl, strip, disks);
  endtask

  // short runs dominate, long and oversized runs now and then
  task automatic random_request(output bit produces);
    logic [31:0] lba;
    logic [6:0]  count;
    case ($urandom_range(9))
      0:       lba = 32'hFFFF_FFFF - $urandom_range(40);
      1:       lba = $urandom_range(200);
      default: lba = $urandom;
    endcase
    case ($urandom_range(19)) inside
      0:          count = 7'd0;
      1:          count = 7'($urandom_range(127, 65));
      2, 3, 4:    count = 7'($urandom_range(64, 9));
      default:    count = 7'($urandom_range(8, 1));
    endcase
    push_request(lba, count);
    produces = (count != 7'd0);
  endtask

  initial begin : stimulus
    int done;
    bit produces;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset setting: plain striping, one disk, one-block strips
    push_request(32'd0, 7'd1);
    push_request(32'hFFFF_FFFF, 7'd3);
    push_request(32'd1234, 7'd0);
    push_request($urandom, 7'd127);

    // striping, zero strip size, full array
    apply_setting(rbm_pkg::LVL_STRIPE, 16'd0, 5'd16);
    push_request(32'hFFFF_FFFF, 7'd2);
    push_request($urandom, 7'd64);

    // mirrors, even and odd disk counts
    apply_setting(rbm_pkg::LVL_MIRROR, 16'd4, 5'd4);
    push_request(32'd0, 7'd10);
    push_request($urandom, 7'd5);
    apply_setting(rbm_pkg::LVL_MIRROR, 16'hFFFF, 5'd5);
    push_request(32'hFFFF_FFF0, 7'd20);

    // dedicated parity, smallest legal array and one too small
    apply_setting(rbm_pkg::LVL_PARITY, 16'd2, 5'd3);
    push_request(32'd0, 7'd12);
    push_request($urandom, 7'd65);
    apply_setting(rbm_pkg::LVL_PARITY, 16'd3, 5'd2);
    push_request(32'd100, 7'd6);

    // rotating parity, parity walking across the disks
    apply_setting(rbm_pkg::LVL_ROTATE, 16'd1, 5'd5);
    push_request(32'd0, 7'd25);
    push_request($urandom, 7'd9);
    apply_setting(rbm_pkg::LVL_ROTATE, 16'd8, 5'd16);
    push_request($urandom, 7'd40);
    apply_setting(rbm_pkg::LVL_ROTATE, 16'd1, 5'd1);
    push_request(32'd5, 7'd4);

    // disk counts out of range get clamped and flagged
    apply_setting(rbm_pkg::LVL_STRIPE, 16'd7, 5'd0);
    push_request(32'd0, 7'd5);
    apply_setting(rbm_pkg::LVL_MIRROR, 16'd2, 5'd31);
    push_request($urandom, 7'd8);

    // random part, each setting drained before the next
    done = 0;
    while (done < RANDOM_REQUESTS) begin
      random_setting();
      for (int k = 0; k < REQUESTS_PER_SETTING && done < RANDOM_REQUESTS; ) begin
        if (done < RANDOM_REQUESTS / 3) begin
          send_idle = 30;
          recv_idle = 50;
        end else if (done < 2 * RANDOM_REQUESTS / 3) begin
          send_idle = 50;
          recv_idle = 30;
        end else begin
          send_idle = 0;
          recv_idle = 0;
        end
        random_request(produces);
        if (produces) begin
          done++;
          k++;
        end
      end
    end

    drain();
    $display("sent %0d block requests across %0d array settings", requests_sent,
             settings_used + 1);
    $display("checked %0d block mappings over all four raid levels", results_checked);
    if (fail_count == 0) begin
      $display("tb_raid_block_mapper_top OK");
    end else begin
      $display("tb_raid_block_mapper_top NOT OK");
    end
    $finish;
  end

endmodule
